// ===== rtl/separable_box_mean_filter_assert.svh =====
// Assertion macros shared by the box mean filter modules.
`ifndef SEPARABLE_BOX_MEAN_FILTER_ASSERT_SVH
`define SEPARABLE_BOX_MEAN_FILTER_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define SBMF_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A consequence that holds in the same cycle as its antecedent.
`define SBMF_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// A consequence that holds in the cycle after its antecedent.
`define SBMF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/sbmf_pkg.sv =====
// Shared constants and types of the separable box mean filter.
`timescale 1ns / 1ps
package sbmf_pkg;

  localparam int PIX_W       = 8;
  localparam int POS_W       = 10;
  localparam int DIM_W       = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int MAX_HEIGHT  = 1024;
  localparam int DIM_RESET   = 512;
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int RADIUS_DEF  = 3;
  localparam int OUT_DEPTH   = 4;
  localparam int TDATA_W     = 32;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);

  typedef struct packed {
    logic             frame_last;
    logic [POS_W-1:0] out_col;
    logic [POS_W-1:0] out_row;
    logic [PIX_W-1:0] mean_value;
  } result_t;

endpackage

// ===== rtl/sbmf_out_fifo.sv =====
// Small output queue that decouples the filter pipeline from the result receiver.
`timescale 1ns / 1ps
`include "separable_box_mean_filter_assert.svh"
module sbmf_out_fifo #(
  parameter int DEPTH = sbmf_pkg::OUT_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  sbmf_pkg::result_t          wr_data,
  output logic                       rd_valid,
  input  logic                       rd_ready,
  output sbmf_pkg::result_t          rd_data,
  output logic [$clog2(DEPTH+1)-1:0] level
);
  import sbmf_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int LVL_W = $clog2(DEPTH+1);

  result_t          store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             pop;

  assign pop      = rd_valid && rd_ready;
  assign rd_valid = (level != '0);
  assign rd_data  = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (wr_en && !pop) begin
        level <= level + LVL_W'(1);
      end else if (!wr_en && pop) begin
        level <= level - LVL_W'(1);
      end
    end
  end

  `SBMF_ASSERT_IMPL(no_push_when_full, wr_en, level < LVL_W'(DEPTH), "push into a full queue")
  `SBMF_ASSERT_NEXT(level_holds, !wr_en && !pop, $stable(level), "level moved without a request")
  `SBMF_ASSERT_NEXT(level_grows, wr_en && !pop, level == $past(level) + LVL_W'(1), "level did not grow on push")

endmodule

// ===== rtl/separable_box_mean_filter.sv =====
// Top level of the separable box mean filter over a raster-order grey pixel stream.
`timescale 1ns / 1ps
`include "separable_box_mean_filter_assert.svh"
// Usage:
// Pixels enter on s_axis in raster order, one request per pixel. For every pixel at
// least RADIUS away from each edge the block emits one request on m_axis carrying the
// truncated mean of the (2*RADIUS+1) square around it, its row and column, and tlast
// on the last interior pixel of the frame. Border pixels produce nothing.
// Throughput is one pixel per clock while s_axis_tready is high: the line store is a
// single memory whose word holds all 2*RADIUS stored rows of one column, read into a
// register when a pixel is taken and written back with the new pixel shifted in on the
// next cycle. A result moves from stage 1 through stage 2 into the output queue.
// The cfg channel writes image_width (index 0) or image_height (index 1); it is always
// ready; any accepted write to either register restarts the frame. The user must issue
// writes only while the block is idle; the block does not check it. Values outside
// [2*RADIUS+1, max] are clamped on use. Reset sets both dimensions to 512 and restarts
// the frame; the line store is not cleared as each entry is written in a frame before
// it is used. A stalled receiver fills a four-entry output queue; s_axis_tready falls
// once the queue and the two pipeline stages together have no room for another result.
module separable_box_mean_filter #(
  parameter int MAX_WIDTH = sbmf_pkg::MAX_WIDTH_DEF,
  parameter int RADIUS    = sbmf_pkg::RADIUS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // Pixel input. tdata: pixel[7:0].
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,
  // Result output. tdata: mean_value[7:0], out_row[17:8], out_col[27:18], zero[31:28].
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [sbmf_pkg::TDATA_W-1:0]     m_axis_tdata,
  output logic                             m_axis_tlast,
  // Configuration writes.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sbmf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sbmf_pkg::DIM_W-1:0]       cfg_data
);
  import sbmf_pkg::*;

  localparam int TAPS   = 2 * RADIUS + 1;
  localparam int LINES  = 2 * RADIUS;
  localparam int AREA   = TAPS * TAPS;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WD_W   = COL_W + 1;
  localparam int CMP_W  = (WD_W > DIM_W) ? WD_W : DIM_W;
  localparam int LW     = LINES * PIX_W;
  localparam int CS_W   = $clog2(TAPS * 255 + 1);
  localparam int TOT_W  = $clog2(AREA * 255 + 1);
  // Division by AREA as a multiply by a rounded-up reciprocal; exact for all sums.
  localparam int SHIFT  = $clog2(AREA * AREA * 256);
  localparam int RECIP  = (2 ** SHIFT + AREA - 1) / AREA;
  localparam int K_W    = $clog2(RECIP + 1);
  localparam int PROD_W = TOT_W + K_W;
  localparam int LVL_W  = $clog2(OUT_DEPTH + 1);
  localparam int OCC_W  = LVL_W + 1;

  // Configuration registers.
  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic             restart;

  // Frame position of the next pixel.
  logic [COL_W-1:0] col_count;
  logic [POS_W-1:0] row_count;

  // Clamped dimensions.
  logic [CMP_W-1:0] width_ext;
  logic [CMP_W-1:0] width_clamped;
  logic [WD_W-1:0]  width_used;
  logic [DIM_W-1:0] height_used;
  logic             last_col;
  logic             last_row;
  logic             take;

  // Line store: one word per column holding the previous LINES rows, newest lowest.
  logic [LW-1:0]    line_mem [MAX_WIDTH];
  logic [LW-1:0]    line_word;

  // Stage 1: line word is available, column sum and window update.
  logic             s1_valid;
  logic [PIX_W-1:0] s1_pixel;
  logic [COL_W-1:0] s1_col;
  logic [POS_W-1:0] s1_row;
  logic             s1_row_ok;
  logic             s1_col_ok;
  logic             s1_last;
  logic [CS_W-1:0]  col_sum;
  logic [LW-1:0]    line_word_next;

  logic [CS_W-1:0]  window [TAPS];
  logic [TOT_W-1:0] total;
  logic [TOT_W-1:0] total_next;
  logic [TOT_W-1:0] window_sum;

  // Stage 2: total of the square, divided on the way into the queue.
  logic             s2_valid;
  logic [TOT_W-1:0] s2_total;
  logic [POS_W-1:0] s2_row;
  logic [POS_W-1:0] s2_col;
  logic             s2_last;
  logic [PROD_W-1:0] product;

  result_t          push_data;
  result_t          head;
  logic [LVL_W-1:0] fifo_level;
  logic [OCC_W-1:0] occupancy;

  assign cfg_ready = 1'b1;
  assign restart   = cfg_valid && cfg_ready &&
                     (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_W'(DIM_RESET);
      image_height <= DIM_W'(DIM_RESET);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WIDTH:  image_width  <= cfg_data;
        REG_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // The register keeps what was written; the clamp applies where it is used.
  always_comb begin
    width_ext = CMP_W'(image_width);
    if (width_ext < CMP_W'(TAPS)) begin
      width_clamped = CMP_W'(TAPS);
    end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
      width_clamped = CMP_W'(MAX_WIDTH);
    end else begin
      width_clamped = width_ext;
    end
    width_used = WD_W'(width_clamped);
    if (image_height < DIM_W'(TAPS)) begin
      height_used = DIM_W'(TAPS);
    end else if (image_height > DIM_W'(MAX_HEIGHT)) begin
      height_used = DIM_W'(MAX_HEIGHT);
    end else begin
      height_used = image_height;
    end
  end

  assign last_col = (col_count == COL_W'(width_used - WD_W'(1)));
  assign last_row = (row_count == POS_W'(height_used - DIM_W'(1)));

  // Room for the new pixel's result must exist even if every request in flight emits.
  assign occupancy     = OCC_W'(fifo_level) + OCC_W'(s1_valid) + OCC_W'(s2_valid);
  assign s_axis_tready = (occupancy < OCC_W'(OUT_DEPTH));
  assign take          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col_count <= '0;
      row_count <= '0;
    end else if (take) begin
      if (last_col) begin
        col_count <= '0;
        row_count <= last_row ? '0 : row_count + POS_W'(1);
      end else begin
        col_count <= col_count + COL_W'(1);
      end
    end
  end

  // The write of a column lands in the cycle after its read. The next read of the same
  // column is at least a full row later, so reads and writes never meet.
  always_ff @(posedge clk) begin
    if (take) begin
      line_word <= line_mem[col_count];
    end
    if (s1_valid) begin
      line_mem[s1_col] <= line_word_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_pixel  <= s_axis_tdata;
      s1_col    <= col_count;
      s1_row    <= row_count;
      s1_row_ok <= (row_count >= POS_W'(LINES));
      s1_col_ok <= (col_count >= COL_W'(LINES));
      s1_last   <= last_row && last_col;
    end
  end

  always_comb begin
    col_sum = CS_W'(s1_pixel);
    for (int k = 0; k < LINES; k++) begin
      col_sum = col_sum + CS_W'(line_word[k*PIX_W +: PIX_W]);
    end
    line_word_next = {line_word[LW-PIX_W-1:0], s1_pixel};
  end

  // Running horizontal sum: add the newest column sum, drop the one leaving the window.
  assign total_next = total + TOT_W'(col_sum) - TOT_W'(window[0]);

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      total <= '0;
      for (int k = 0; k < TAPS; k++) begin
        window[k] <= '0;
      end
    end else if (s1_valid && s1_row_ok) begin
      total <= total_next;
      for (int k = 0; k < TAPS - 1; k++) begin
        window[k] <= window[k+1];
      end
      window[TAPS-1] <= col_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid && s1_row_ok && s1_col_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_total <= total_next;
      s2_row   <= POS_W'(s1_row - POS_W'(RADIUS));
      s2_col   <= POS_W'(s1_col - COL_W'(RADIUS));
      s2_last  <= s1_last;
    end
  end

  assign product = PROD_W'(s2_total) * PROD_W'(RECIP);

  always_comb begin
    push_data.mean_value = product[SHIFT +: PIX_W];
    push_data.out_row    = s2_row;
    push_data.out_col    = s2_col;
    push_data.frame_last = s2_last;
  end

  sbmf_out_fifo #(
    .DEPTH(OUT_DEPTH)
  ) u_out_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (s2_valid),
    .wr_data  (push_data),
    .rd_valid (m_axis_tvalid),
    .rd_ready (m_axis_tready),
    .rd_data  (head),
    .level    (fifo_level)
  );

  assign m_axis_tdata = {(TDATA_W - 2 * POS_W - PIX_W)'(0),
                         head.out_col, head.out_row, head.mean_value};
  assign m_axis_tlast = head.frame_last;

  // Checking aid: the window total recomputed from the stored column sums.
  always_comb begin
    window_sum = '0;
    for (int k = 0; k < TAPS; k++) begin
      window_sum = window_sum + TOT_W'(window[k]);
    end
  end

  `SBMF_ASSERT_IMPL(no_line_collision, take && s1_valid, col_count != s1_col, "line store read meets write")
  `SBMF_ASSERT(running_total_ok, total == window_sum, "running total out of step with window")
  `SBMF_ASSERT(queue_never_overrun, occupancy <= OCC_W'(OUT_DEPTH), "results in flight exceed queue room")

endmodule

// ===== dv/tb_separable_box_mean_filter.sv =====
// Self-checking testbench of the separable 7x7 box mean filter.
`timescale 1ns / 1ps
module tb_separable_box_mean_filter;
  import sbmf_pkg::*;

  // Geometry of the filter as the block is built with its default parameters.
  localparam int TAPS      = 2 * RADIUS_DEF + 1;
  localparam int LINE_ROWS = 2 * RADIUS_DEF;
  localparam int AREA      = TAPS * TAPS;
  localparam int MAX_W     = MAX_WIDTH_DEF;

  // A request may legally be absent for a long while under random stalls and gaps,
  // but never for this many cycles in a row.
  localparam int WATCHDOG_LIMIT = 4000;
  // Pixels pass through the block's pipeline; this settling time covers pixels that
  // produce nothing but may still be in flight when the last result has arrived.
  localparam int SETTLE_CYCLES  = 8;
  localparam int RANDOM_PIXELS  = 260;

  // Indexes with no register behind them; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

  typedef enum int {
    STYLE_BLACK,
    STYLE_WHITE,
    STYLE_UNIFORM,
    STYLE_BINARY,
    STYLE_RAMP,
    STYLE_BRIGHT
  } pixel_style_e;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]   m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data  = '0;

  separable_box_mean_filter #(
    .MAX_WIDTH(MAX_WIDTH_DEF),
    .RADIUS   (RADIUS_DEF)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Local copy of the filter: line stores, column-sum window, raster position and
  // the two dimension registers exactly as written (clamping happens on use).
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0] line_mem [LINE_ROWS][MAX_W];
  int unsigned      col_window [TAPS];
  int unsigned      row_pos;
  int unsigned      col_pos;
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  result_t          pending_means [$];

  // Stimulus bookkeeping shared by the sequencer, the driver and the monitor.
  logic [7:0]  pixel_backlog [$];
  int unsigned pixels_queued  = 0;
  int unsigned pixels_taken   = 0;
  int unsigned cfg_taken      = 0;
  int unsigned results_seen   = 0;
  int unsigned settings_used  = 0;
  int unsigned error_count    = 0;
  int unsigned quiet_cycles   = 0;
  bit          px_taken       = 1'b0;
  bit          steady_flow    = 1'b0;
  int unsigned gap_left       = 0;
  int unsigned ready_left     = 0;

  function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned hi);
    if (v < TAPS) begin
      return TAPS;
    end
    if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  function automatic void restart_frame();
    row_pos = 0;
    col_pos = 0;
    foreach (col_window[k]) col_window[k] = 0;
  endfunction

  // Takes one pixel through the filter and queues the smoothed result, if the pixel
  // completes a full 7x7 neighbourhood.
  function automatic void smooth_pixel(input logic [PIX_W-1:0] px);
    int unsigned w;
    int unsigned h;
    int unsigned r;
    int unsigned c;
    int unsigned colsum;
    int unsigned total;
    result_t     res;
    w = clamp_dim(width_reg, MAX_W);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    r = row_pos;
    c = col_pos;
    if (c >= w) c = 0;
    if (r >= h) r = 0;

    // Vertical sum of this column over the current pixel and the stored rows, then
    // the stores shift down by one row.
    colsum = px;
    for (int k = 0; k < LINE_ROWS; k++) colsum += line_mem[k][c];
    for (int k = LINE_ROWS - 1; k > 0; k--) line_mem[k][c] = line_mem[k - 1][c];
    line_mem[0][c] = px;

    // Column sums only enter the window once all seven rows are real.
    if (r >= LINE_ROWS) begin
      for (int k = 0; k < TAPS - 1; k++) col_window[k] = col_window[k + 1];
      col_window[TAPS - 1] = colsum;
      if (c >= LINE_ROWS) begin
        total = 0;
        for (int k = 0; k < TAPS; k++) total += col_window[k];
        res.mean_value = PIX_W'(total / AREA);
        res.out_row    = POS_W'(r - RADIUS_DEF);
        res.out_col    = POS_W'(c - RADIUS_DEF);
        res.frame_last = (r == h - 1) && (c == w - 1);
        pending_means.push_back(res);
      end
    end

    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endfunction

  // Idle stretch lengths: mostly short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      return $urandom_range(0, 2);
    end else if (pick < 95) begin
      return $urandom_range(3, 12);
    end
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [7:0] pick_pixel(input pixel_style_e style, input int unsigned idx);
    case (style)
      STYLE_BLACK:   return 8'h00;
      STYLE_WHITE:   return 8'hFF;
      STYLE_BINARY:  return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      STYLE_RAMP:    return 8'(idx * 7 + $urandom_range(0, 15));
      STYLE_BRIGHT:  return 8'($urandom_range(230, 255));
      default:       return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: changes the pixel stream at the falling edge. A new pixel is presented
  // only once the previous request was taken (seen by the monitor at the rising
  // edge), so tvalid never drops while a pixel is waiting.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || px_taken) begin
      if (gap_left != 0) begin
        gap_left      <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pixel_backlog.size() != 0) begin
        s_axis_tdata  <= pixel_backlog.pop_front();
        s_axis_tvalid <= 1'b1;
        gap_left      <= (steady_flow || $urandom_range(0, 1)) ? 0 : idle_len();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // The result receiver holds tready at one level for a random number of cycles.
  always @(negedge clk) begin
    if (ready_left != 0) begin
      ready_left <= ready_left - 1;
    end else begin
      m_axis_tready <= steady_flow || ($urandom_range(0, 3) != 0);
      ready_left    <= idle_len();
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: samples every handshake at the rising edge. A result request is
  // checked against the oldest expectation before the pixel taken in the same cycle
  // is predicted; a result can never appear in the same cycle as its own pixel.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      foreach (line_mem[k, c]) line_mem[k][c] = '0;
      width_reg  = DIM_W'(DIM_RESET);
      height_reg = DIM_W'(DIM_RESET);
      restart_frame();
      px_taken <= 1'b0;
    end else begin
      px_taken <= s_axis_tvalid && s_axis_tready;

      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (pending_means.size() == 0) begin
          error_count++;
          $error("result request with nothing expected: tdata %h tlast %b",
                 m_axis_tdata, m_axis_tlast);
        end else begin
          want = pending_means.pop_front();
          if (m_axis_tdata[7:0] !== want.mean_value) begin
            error_count++;
            $error("mean_value: expected %0d, got %0d", want.mean_value, m_axis_tdata[7:0]);
          end
          if (m_axis_tdata[17:8] !== want.out_row) begin
            error_count++;
            $error("out_row: expected %0d, got %0d", want.out_row, m_axis_tdata[17:8]);
          end
          if (m_axis_tdata[27:18] !== want.out_col) begin
            error_count++;
            $error("out_col: expected %0d, got %0d", want.out_col, m_axis_tdata[27:18]);
          end
          if (m_axis_tlast !== want.frame_last) begin
            error_count++;
            $error("frame_last: expected %0d, got %0d", want.frame_last, m_axis_tlast);
          end
          if (m_axis_tdata[31:28] !== 4'h0) begin
            error_count++;
            $error("tdata pad: expected 0, got %0h", m_axis_tdata[31:28]);
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        smooth_pixel(s_axis_tdata);
        pixels_taken <= pixels_taken + 1;
      end

      // Either dimension write restarts the frame; spare indexes change nothing.
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_WIDTH) begin
          width_reg = cfg_data;
          restart_frame();
        end else if (cfg_index == REG_HEIGHT) begin
          height_reg = cfg_data;
          restart_frame();
        end
        cfg_taken <= cfg_taken + 1;
      end
    end
  end

  // Watchdog: any accepted request on any channel counts as progress.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no request accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_separable_box_mean_filter: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    int unsigned seen;
    seen = cfg_taken;
    @(negedge clk);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    while (cfg_taken == seen) @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic queue_pixels(input int unsigned count, input pixel_style_e style);
    for (int unsigned i = 0; i < count; i++) begin
      pixel_backlog.push_back(pick_pixel(style, i));
    end
    pixels_queued += count;
  endtask

  // Waits until every queued pixel is taken and every expected result has arrived,
  // then lets the pipeline run empty so a register write finds the block idle.
  task automatic settle();
    while (pixels_taken != pixels_queued || pending_means.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int unsigned  random_pixels;
    int unsigned  w;
    int unsigned  h;
    int unsigned  count;
    bit           set_w;
    bit           set_h;
    pixel_style_e style;

    random_pixels = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Smallest frame, both sizes written below the legal minimum so they clamp to 7.
    // A white frame gives the top mean on its only interior pixel; the following
    // black frame runs after the counters wrap with no write in between.
    steady_flow = 1'b1;
    cfg_write(REG_WIDTH, DIM_W'(0));
    cfg_write(REG_HEIGHT, DIM_W'(3));
    settings_used++;
    queue_pixels(TAPS * TAPS, STYLE_WHITE);
    queue_pixels(TAPS * TAPS, STYLE_BLACK);
    settle();

    // Writes to the spare indexes in the middle of a frame must neither change a
    // dimension nor restart the frame, so the frame simply carries on afterwards.
    steady_flow = 1'b0;
    cfg_write(REG_WIDTH, DIM_W'(9));
    cfg_write(REG_HEIGHT, DIM_W'(8));
    settings_used++;
    queue_pixels(30, STYLE_UNIFORM);
    settle();
    cfg_write(REG_SPARE_LO, DIM_W'(11'h7FF));
    cfg_write(REG_SPARE_HI, DIM_W'(11'h155));
    queue_pixels(9 * 8 - 30 + 9 * 8, STYLE_UNIFORM);
    settle();

    // Random small frames. Most run one or two whole frames; about a quarter stop
    // part way, so the next write restarts a frame in progress. The last one is cut
    // short so the random part keeps to its pixel budget.
    while (random_pixels < RANDOM_PIXELS) begin
      set_w = $urandom_range(0, 1);
      set_h = $urandom_range(0, 1);
      if (!set_h) set_w = 1'b1;
      if (set_w) cfg_write(REG_WIDTH, DIM_W'($urandom_range(0, 18)));
      if (set_h) cfg_write(REG_HEIGHT, DIM_W'($urandom_range(2, 12)));
      settings_used++;
      w = clamp_dim(width_reg, MAX_W);
      h = clamp_dim(height_reg, MAX_HEIGHT);
      if ($urandom_range(0, 3) == 0) begin
        count = $urandom_range(1, w * h - 1);
      end else begin
        count = w * h * $urandom_range(1, 2);
      end
      if (count > RANDOM_PIXELS - random_pixels) begin
        count = RANDOM_PIXELS - random_pixels;
      end
      style = pixel_style_e'($urandom_range(STYLE_BLACK, STYLE_BRIGHT));
      if ($urandom_range(0, 2) == 0) style = STYLE_UNIFORM;
      steady_flow = ($urandom_range(0, 3) == 0);
      queue_pixels(count, style);
      random_pixels += count;
      settle();
    end

    // All-ones width clamps to the widest row. These pixels all stay in row zero, so
    // no result may appear; a width clamped to the minimum would emit some.
    steady_flow = $urandom_range(0, 1);
    cfg_write(REG_WIDTH, DIM_W'(11'h7FF));
    cfg_write(REG_HEIGHT, DIM_W'(7));
    settings_used++;
    queue_pixels(60, STYLE_UNIFORM);
    settle();

    // All-ones height clamps to the tallest frame: a narrow frame runs on past row
    // six with no last-pixel flag and no wrap.
    steady_flow = $urandom_range(0, 1);
    cfg_write(REG_WIDTH, DIM_W'(7));
    cfg_write(REG_HEIGHT, DIM_W'(11'h7FF));
    settings_used++;
    queue_pixels(TAPS * 12, STYLE_RAMP);
    settle();

    $display("Run covered %0d pixels and %0d checked results over %0d frame sizes,",
             pixels_taken, results_seen, settings_used);
    $display("including clamped minimum and maximum dimensions and spare-index writes.");
    if (error_count == 0 && pending_means.size() == 0) begin
      $display("tb_separable_box_mean_filter: PASS");
    end else begin
      $display("tb_separable_box_mean_filter: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/sbmf_pkg.sv
rtl/sbmf_out_fifo.sv
rtl/separable_box_mean_filter.sv
dv/tb_separable_box_mean_filter.sv
